### sv/sfd_pkg.sv
// Shared types and constants for the sync-framed byte deframer.
// No dependencies; used by the register block, the top level and the bench.
package sfd_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_HEADER  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC     = 3'd4
    } t_phase;

    // Result event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PAYLOAD = 2'd1;
    localparam logic [1:0] EV_GOOD    = 2'd2;
    localparam logic [1:0] EV_CRC_ERR = 2'd3;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_FIRST_SYNC  = 2'd0;
    localparam logic [1:0] REG_SECOND_SYNC = 2'd1;
    localparam logic [1:0] REG_GAP_TIMEOUT = 2'd2;

    localparam int APB_ADDR_W = 4;

    // Register reset values
    localparam logic [7:0]  FIRST_SYNC_RST  = 8'hAA;
    localparam logic [7:0]  SECOND_SYNC_RST = 8'h55;
    localparam logic [15:0] GAP_TIMEOUT_RST = 16'd200;

    // Header byte offsets
    localparam int HDR_LEN_LO = 0;
    localparam int HDR_LEN_HI = 1;
    localparam int HDR_CMD    = 2;
    localparam int HDR_SEQ_LO = 3;
    localparam int HDR_SEQ_HI = 4;
    localparam int HDR_BYTES  = 6;

    // CRC-16/MODBUS
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [7:0]  first_sync;
        logic [7:0]  second_sync;
        logic [15:0] gap_timeout;
    } t_cfg;

    // One byte through the reflected CRC, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### sv/sfd_if.sv
// Valid/ready stream interfaces for received bytes and parser results.
// Depends on nothing beyond plain logic types.
interface sfd_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic [31:0] arrival_ms;

    modport source(output valid, rx_byte, arrival_ms, input ready);
    modport sink(input valid, rx_byte, arrival_ms, output ready);
endinterface

interface sfd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [7:0]  payload_data;
    logic [7:0]  payload_index;
    logic [7:0]  pkt_cmd;
    logic [15:0] pkt_seq;
    logic [7:0]  pkt_flags;
    logic [8:0]  pkt_length;
    logic [31:0] ok_total;
    logic [31:0] crc_fail_total;

    modport source(output valid, event_res, payload_data, payload_index, pkt_cmd,
                   pkt_seq, pkt_flags, pkt_length, ok_total, crc_fail_total,
                   input ready);
    modport sink(input valid, event_res, payload_data, payload_index, pkt_cmd,
                 pkt_seq, pkt_flags, pkt_length, ok_total, crc_fail_total,
                 output ready);
endinterface

### sv/sfd_cfg_regs.sv
// APB-style configuration registers: sync bytes and inter-byte gap timeout.
// Depends on sfd_pkg for the register map, reset values and t_cfg.
module sfd_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output sfd_pkg::t_cfg                  o_cfg
);

    sfd_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_sync  <= sfd_pkg::FIRST_SYNC_RST;
            r_cfg.second_sync <= sfd_pkg::SECOND_SYNC_RST;
            r_cfg.gap_timeout <= sfd_pkg::GAP_TIMEOUT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                sfd_pkg::REG_FIRST_SYNC:  r_cfg.first_sync  <= pwdata[7:0];
                sfd_pkg::REG_SECOND_SYNC: r_cfg.second_sync <= pwdata[7:0];
                sfd_pkg::REG_GAP_TIMEOUT: r_cfg.gap_timeout <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            sfd_pkg::REG_FIRST_SYNC:  prdata = {24'h0, r_cfg.first_sync};
            sfd_pkg::REG_SECOND_SYNC: prdata = {24'h0, r_cfg.second_sync};
            sfd_pkg::REG_GAP_TIMEOUT: prdata = {16'h0, r_cfg.gap_timeout};
            default:                  prdata = 32'h0;
        endcase
    end

endmodule

### sv/sync_frame_deframer_crc16_unit.sv
// Top level of the sync-framed byte deframer with CRC-16/MODBUS check.
// Depends on sfd_pkg, the sfd_in_if / sfd_out_if interfaces and sfd_cfg_regs.
//
// Usage:
//   i_in carries one received byte plus its millisecond timestamp per beat.
//   Every accepted byte produces exactly one beat on o_out: event_res tells
//   whether it was nothing, a payload byte (with data and index), or a frame
//   verdict (good / CRC error, with command, sequence, flags and length).
//   ok_total and crc_fail_total ride along on every beat and wrap.
//   Registers (APB, byte address 4*i): first sync byte, second sync byte,
//   gap timeout in ms. Write them only while no bytes are in flight.
// Timing:
//   The result is registered and valid in the cycle after input accept. The
//   parser state, byte-wise CRC and timeout compare are all combinational,
//   so a byte is taken every cycle while the receiver keeps up; sustained
//   rate is one byte per clock. When the receiver stalls, the result beat
//   holds in the output register and i_in.ready drops until it is taken.
// Reset:
//   Synchronous, active low: parser back to first-sync hunt, CRC to FFFF,
//   counters and registers to their defaults, output empty.
module sync_frame_deframer_crc16_unit #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sfd_in_if.sink                         i_in,
    sfd_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int CNT_RAW = $clog2(MAX_PAYLOAD + 1);
    localparam int CNT_W   = (CNT_RAW < 3) ? 3 : CNT_RAW;
    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

    sfd_pkg::t_cfg cfg;

    sfd_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Parser state
    sfd_pkg::t_phase   r_phase, n_phase;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [15:0]       r_len, n_len;
    logic [7:0]        r_cmd, n_cmd;
    logic [15:0]       r_seq, n_seq;
    logic [7:0]        r_flags, n_flags;
    logic [15:0]       r_crc, n_crc;
    logic [7:0]        r_crc_lo, n_crc_lo;
    logic [31:0]       r_last_ms;
    logic [31:0]       r_ok_cnt, n_ok_cnt;
    logic [31:0]       r_err_cnt, n_err_cnt;

    // Result register
    logic              r_out_valid;
    logic [1:0]        r_ev, n_ev;
    logic [7:0]        r_pdata, n_pdata;
    logic [7:0]        r_pidx, n_pidx;
    logic [7:0]        r_ocmd, n_ocmd;
    logic [15:0]       r_oseq, n_oseq;
    logic [7:0]        r_oflags, n_oflags;
    logic [8:0]        r_olen, n_olen;

    // Working values after the gap check
    sfd_pkg::t_phase   g_phase;
    logic [CNT_W-1:0]  g_cnt;
    logic [15:0]       g_len;
    logic [15:0]       g_crc;
    logic [CNT_W-1:0]  cnt_inc;
    logic [15:0]       cnt_ext;
    logic [15:0]       crc_in;
    logic [31:0]       gap_ms;
    logic              gap_hit;
    logic [7:0]        b;
    logic              in_beat;

    assign b       = i_in.rx_byte;
    assign in_beat = i_in.valid & i_in.ready;
    assign i_in.ready = ~r_out_valid | o_out.ready;

    assign gap_ms  = i_in.arrival_ms - r_last_ms;
    assign gap_hit = (r_phase != sfd_pkg::PH_SYNC1) && (gap_ms > {16'h0, cfg.gap_timeout});

    // Timeout restart ahead of the phase decode
    always_comb begin
        if (gap_hit) begin
            g_phase = sfd_pkg::PH_SYNC1;
            g_cnt   = '0;
            g_len   = 16'h0;
            g_crc   = sfd_pkg::CRC_INIT;
        end else begin
            g_phase = r_phase;
            g_cnt   = r_cnt;
            g_len   = r_len;
            g_crc   = r_crc;
        end
    end

    assign cnt_inc = g_cnt + 1'b1;
    assign cnt_ext = 16'(g_cnt);
    assign crc_in  = sfd_pkg::crc_byte(g_crc, b);

    // Phase decode: next state and the result for this beat
    always_comb begin
        n_phase   = g_phase;
        n_cnt     = g_cnt;
        n_len     = g_len;
        n_crc     = g_crc;
        n_cmd     = r_cmd;
        n_seq     = r_seq;
        n_flags   = r_flags;
        n_crc_lo  = r_crc_lo;
        n_ok_cnt  = r_ok_cnt;
        n_err_cnt = r_err_cnt;
        n_ev      = sfd_pkg::EV_NONE;
        n_pdata   = 8'h0;
        n_pidx    = 8'h0;
        n_ocmd    = 8'h0;
        n_oseq    = 16'h0;
        n_oflags  = 8'h0;
        n_olen    = 9'h0;

        unique case (g_phase)
            sfd_pkg::PH_SYNC1: begin
                if (b == cfg.first_sync) begin
                    n_phase = sfd_pkg::PH_SYNC2;
                end
            end
            sfd_pkg::PH_SYNC2: begin
                n_cnt = '0;
                n_crc = sfd_pkg::CRC_INIT;
                if (b == cfg.second_sync) begin
                    n_phase = sfd_pkg::PH_HEADER;
                end else begin
                    n_phase = sfd_pkg::PH_SYNC1;
                    n_len   = 16'h0;
                end
            end
            sfd_pkg::PH_HEADER: begin
                if (g_cnt == CNT_W'(sfd_pkg::HDR_LEN_LO)) begin
                    n_len = {8'h0, b};
                end else if (g_cnt == CNT_W'(sfd_pkg::HDR_LEN_HI)) begin
                    n_len = {b, g_len[7:0]};
                end else if (g_cnt == CNT_W'(sfd_pkg::HDR_CMD)) begin
                    n_cmd = b;
                end else if (g_cnt == CNT_W'(sfd_pkg::HDR_SEQ_LO)) begin
                    n_seq = {8'h0, b};
                end else if (g_cnt == CNT_W'(sfd_pkg::HDR_SEQ_HI)) begin
                    n_seq = {b, r_seq[7:0]};
                end else begin
                    n_flags = b;
                end
                // CRC covers command onward
                if (g_cnt >= CNT_W'(sfd_pkg::HDR_CMD)) begin
                    n_crc = crc_in;
                end
                n_cnt = cnt_inc;
                if (cnt_inc >= CNT_W'(sfd_pkg::HDR_BYTES)) begin
                    n_cnt = '0;
                    if (n_len > MAX_LEN) begin
                        n_phase = sfd_pkg::PH_SYNC1;
                        n_len   = 16'h0;
                        n_crc   = sfd_pkg::CRC_INIT;
                    end else if (n_len == 16'h0) begin
                        n_phase = sfd_pkg::PH_CRC;
                    end else begin
                        n_phase = sfd_pkg::PH_PAYLOAD;
                    end
                end
            end
            sfd_pkg::PH_PAYLOAD: begin
                n_ev    = sfd_pkg::EV_PAYLOAD;
                n_pdata = b;
                n_pidx  = cnt_ext[7:0];
                n_crc   = crc_in;
                n_cnt   = cnt_inc;
                if (16'(cnt_inc) >= g_len) begin
                    n_cnt   = '0;
                    n_phase = sfd_pkg::PH_CRC;
                end
            end
            sfd_pkg::PH_CRC: begin
                if (g_cnt == '0) begin
                    n_crc_lo = b;
                    n_cnt    = CNT_W'(1);
                end else begin
                    if ({b, r_crc_lo} == g_crc) begin
                        n_ev     = sfd_pkg::EV_GOOD;
                        n_ok_cnt = r_ok_cnt + 32'd1;
                    end else begin
                        n_ev      = sfd_pkg::EV_CRC_ERR;
                        n_err_cnt = r_err_cnt + 32'd1;
                    end
                    n_ocmd   = r_cmd;
                    n_oseq   = r_seq;
                    n_oflags = r_flags;
                    n_olen   = g_len[8:0];
                    // back to hunting
                    n_phase  = sfd_pkg::PH_SYNC1;
                    n_cnt    = '0;
                    n_len    = 16'h0;
                    n_crc    = sfd_pkg::CRC_INIT;
                end
            end
            default: begin
                n_phase = sfd_pkg::PH_SYNC1;
                n_cnt   = '0;
                n_len   = 16'h0;
                n_crc   = sfd_pkg::CRC_INIT;
            end
        endcase
    end

    // Parser state update on each input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= sfd_pkg::PH_SYNC1;
            r_cnt     <= '0;
            r_len     <= 16'h0;
            r_cmd     <= 8'h0;
            r_seq     <= 16'h0;
            r_flags   <= 8'h0;
            r_crc     <= sfd_pkg::CRC_INIT;
            r_crc_lo  <= 8'h0;
            r_last_ms <= 32'h0;
            r_ok_cnt  <= 32'h0;
            r_err_cnt <= 32'h0;
        end else if (in_beat) begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_len     <= n_len;
            r_cmd     <= n_cmd;
            r_seq     <= n_seq;
            r_flags   <= n_flags;
            r_crc     <= n_crc;
            r_crc_lo  <= n_crc_lo;
            r_last_ms <= i_in.arrival_ms;
            r_ok_cnt  <= n_ok_cnt;
            r_err_cnt <= n_err_cnt;
        end
    end

    // Output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_ev     <= n_ev;
            r_pdata  <= n_pdata;
            r_pidx   <= n_pidx;
            r_ocmd   <= n_ocmd;
            r_oseq   <= n_oseq;
            r_oflags <= n_oflags;
            r_olen   <= n_olen;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.event_res      = r_ev;
    assign o_out.payload_data   = r_pdata;
    assign o_out.payload_index  = r_pidx;
    assign o_out.pkt_cmd        = r_ocmd;
    assign o_out.pkt_seq        = r_oseq;
    assign o_out.pkt_flags      = r_oflags;
    assign o_out.pkt_length     = r_olen;
    // counters reflect state after the beat held in the output register
    assign o_out.ok_total       = r_ok_cnt;
    assign o_out.crc_fail_total = r_err_cnt;

endmodule

### test/sync_frame_deframer_crc16_unit_test.sv
`timescale 1ns / 100ps
// Self-checking bench for sync_frame_deframer_crc16_unit: byte stream in, event beats out.
// Depends on sfd_pkg, the sfd_in_if / sfd_out_if interfaces and the top level of the block.
module sync_frame_deframer_crc16_unit_test;

    localparam int MAX_LEN         = 256;
    localparam int BYTES_PER_PHASE = 325;
    localparam int HOLD_CYCLES     = 300;
    localparam int IDLE_LIMIT      = 4000;
    localparam int MAX_PRINTS      = 40;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] arrival_ms;
    } t_rx_item;

    typedef struct packed {
        logic [1:0]  ev_code;
        logic [7:0]  pay_data;
        logic [7:0]  pay_index;
        logic [7:0]  cmd;
        logic [15:0] seq;
        logic [7:0]  flags;
        logic [8:0]  pkt_len;
        logic [31:0] ok_cnt;
        logic [31:0] err_cnt;
    } t_deframe_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [sfd_pkg::APB_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sfd_in_if  in_ch();
    sfd_out_if out_ch();

    sync_frame_deframer_crc16_unit #(.MAX_PAYLOAD(MAX_LEN)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stimulus and scoreboard storage
    t_rx_item      rx_queue[$];
    t_deframe_beat expected_events[$];
    int            bytes_queued = 0;
    int            beats_checked = 0;
    int            mismatch_count = 0;
    int            idle_cycles = 0;
    int            hold_requests = 0;
    int            holds_served = 0;
    logic [31:0]   ts_now;
    bit            resync_next = 1'b0;

    // Shadow configuration, kept in step with the register writes
    logic [7:0]  cfg_sync1;
    logic [7:0]  cfg_sync2;
    logic [15:0] cfg_gap;

    // Shadow parser state
    sfd_pkg::t_phase sh_phase;
    logic [8:0]  sh_cnt;
    logic [15:0] sh_len;
    logic [7:0]  sh_cmd;
    logic [15:0] sh_seq;
    logic [7:0]  sh_flags;
    logic [15:0] sh_crc;
    logic [7:0]  sh_crc_lo;
    logic [31:0] sh_last_ms;
    logic [31:0] sh_ok;
    logic [31:0] sh_err;

    // CRC-16/MODBUS, one bit at a time, LSB first
    function automatic logic [15:0] crc16_modbus(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c = c >> 1;
            if (fb) begin
                c = c ^ sfd_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic restart_shadow();
        sh_phase = sfd_pkg::PH_SYNC1;
        sh_cnt   = '0;
        sh_len   = '0;
        sh_crc   = sfd_pkg::CRC_INIT;
    endtask

    // Advance the shadow parser by one byte and produce the beat it should emit
    task automatic deframe_byte(input logic [7:0] b, input logic [31:0] now,
                                output t_deframe_beat r);
        logic [31:0] dt;
        logic [15:0] rx_crc;
        r = '0;
        dt = now - sh_last_ms;
        if (sh_phase != sfd_pkg::PH_SYNC1 && dt > {16'd0, cfg_gap}) begin
            restart_shadow();
        end
        sh_last_ms = now;
        case (sh_phase)
            sfd_pkg::PH_SYNC1: begin
                if (b == cfg_sync1) begin
                    sh_phase = sfd_pkg::PH_SYNC2;
                end
            end
            sfd_pkg::PH_SYNC2: begin
                if (b == cfg_sync2) begin
                    sh_cnt = '0;
                    sh_crc = sfd_pkg::CRC_INIT;
                    sh_phase = sfd_pkg::PH_HEADER;
                end else begin
                    restart_shadow();
                end
            end
            sfd_pkg::PH_HEADER: begin
                case (int'(sh_cnt))
                    sfd_pkg::HDR_LEN_LO: sh_len = {8'h00, b};
                    sfd_pkg::HDR_LEN_HI: sh_len = {b, sh_len[7:0]};
                    sfd_pkg::HDR_CMD:    sh_cmd = b;
                    sfd_pkg::HDR_SEQ_LO: sh_seq = {8'h00, b};
                    sfd_pkg::HDR_SEQ_HI: sh_seq = {b, sh_seq[7:0]};
                    default:             sh_flags = b;
                endcase
                // length bytes stay out of the CRC
                if (int'(sh_cnt) >= sfd_pkg::HDR_CMD) begin
                    sh_crc = crc16_modbus(sh_crc, b);
                end
                sh_cnt = sh_cnt + 9'd1;
                if (int'(sh_cnt) >= sfd_pkg::HDR_BYTES) begin
                    sh_cnt = '0;
                    if (int'(sh_len) > MAX_LEN) begin
                        restart_shadow();
                    end else if (sh_len == 16'd0) begin
                        sh_phase = sfd_pkg::PH_CRC;
                    end else begin
                        sh_phase = sfd_pkg::PH_PAYLOAD;
                    end
                end
            end
            sfd_pkg::PH_PAYLOAD: begin
                r.ev_code   = sfd_pkg::EV_PAYLOAD;
                r.pay_data  = b;
                r.pay_index = sh_cnt[7:0];
                sh_crc = crc16_modbus(sh_crc, b);
                sh_cnt = sh_cnt + 9'd1;
                if ({7'd0, sh_cnt} >= sh_len) begin
                    sh_cnt = '0;
                    sh_phase = sfd_pkg::PH_CRC;
                end
            end
            sfd_pkg::PH_CRC: begin
                if (sh_cnt == 9'd0) begin
                    sh_crc_lo = b;
                    sh_cnt = 9'd1;
                end else begin
                    rx_crc = {b, sh_crc_lo};
                    if (rx_crc == sh_crc) begin
                        r.ev_code = sfd_pkg::EV_GOOD;
                        sh_ok = sh_ok + 32'd1;
                    end else begin
                        r.ev_code = sfd_pkg::EV_CRC_ERR;
                        sh_err = sh_err + 32'd1;
                    end
                    r.cmd     = sh_cmd;
                    r.seq     = sh_seq;
                    r.flags   = sh_flags;
                    r.pkt_len = sh_len[8:0];
                    restart_shadow();
                end
            end
            default: restart_shadow();
        endcase
        r.ok_cnt  = sh_ok;
        r.err_cnt = sh_err;
    endtask

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        if ($urandom_range(0, 19) < 16) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Timestamp steps: inside the gap limit, just past it, or wherever
    function automatic logic [31:0] normal_delta();
        if (cfg_gap == 16'd0) begin
            return 32'd0;
        end
        if ($urandom_range(0, 9) == 0) begin
            return {16'd0, cfg_gap};
        end
        return $urandom_range(0, (cfg_gap < 16'd20) ? cfg_gap : 20);
    endfunction

    function automatic logic [31:0] timeout_delta();
        logic [31:0] d;
        d = {16'd0, cfg_gap} + 32'd1;
        if ($urandom_range(0, 3) == 0) begin
            d = d + $urandom_range(0, 100000);
        end
        return d;
    endfunction

    function automatic logic [31:0] lead_delta();
        return resync_next ? timeout_delta() : normal_delta();
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic [31:0] delta);
        t_rx_item it;
        ts_now = ts_now + delta;
        it.rx_byte = b;
        it.arrival_ms = ts_now;
        rx_queue.push_back(it);
        bytes_queued++;
    endtask

    // Sync, header, then payload and CRC if the length fits; optionally cut short, corrupted or split by a timeout
    task automatic queue_frame(input logic [15:0] len_field, input logic [7:0] cmd,
                               input logic [15:0] seq, input logic [7:0] flags,
                               input bit corrupt, input int cut, input int gap_pos);
        logic [7:0]  fb[$];
        logic [15:0] crc;
        logic [31:0] d;
        fb = '{cfg_sync1, cfg_sync2, len_field[7:0], len_field[15:8],
               cmd, seq[7:0], seq[15:8], flags};
        crc = sfd_pkg::CRC_INIT;
        for (int i = 4; i < 8; i++) begin
            crc = crc16_modbus(crc, fb[i]);
        end
        if (int'(len_field) <= MAX_LEN) begin
            repeat (int'(len_field)) begin
                fb.push_back(8'($urandom_range(0, 255)));
                crc = crc16_modbus(crc, fb[$]);
            end
            if (corrupt) begin
                crc = crc ^ 16'($urandom_range(1, 65535));
            end
            fb.push_back(crc[7:0]);
            fb.push_back(crc[15:8]);
        end
        if (cut >= 0) begin
            while (fb.size() > cut) begin
                void'(fb.pop_back());
            end
        end
        for (int i = 0; i < fb.size(); i++) begin
            if (i == 0) begin
                d = lead_delta();
            end else if (i == gap_pos) begin
                d = timeout_delta();
            end else begin
                d = normal_delta();
            end
            queue_byte(fb[i], d);
        end
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return 0;
        end else if (r < 75) begin
            return $urandom_range(1, 8);
        end else if (r < 97) begin
            return $urandom_range(9, 40);
        end
        return ($urandom_range(0, 1) == 0) ? MAX_LEN : $urandom_range(200, MAX_LEN - 1);
    endfunction

    // Mostly proper frames, with broken frames and line noise mixed in
    task automatic queue_random_traffic(input int n_bytes);
        int          stop_at;
        int          sel;
        int          plen;
        int          cut;
        int          gap_pos;
        logic [15:0] lf;
        stop_at = bytes_queued + n_bytes;
        while (bytes_queued < stop_at) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                plen = pick_len();
                cut = -1;
                gap_pos = -1;
                if (sel >= 62) begin
                    gap_pos = $urandom_range(1, plen + 9);
                end else if (sel >= 55) begin
                    cut = $urandom_range(1, plen + 9);
                end
                queue_frame(16'(plen), 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                            8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0, cut, gap_pos);
                resync_next = (cut >= 0) || (gap_pos >= 0);
            end else if (sel < 78) begin
                lf = ($urandom_range(0, 1) == 0) ? 16'(MAX_LEN + 1)
                                                 : 16'($urandom_range(MAX_LEN + 2, 65535));
                queue_frame(lf, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                            8'($urandom_range(0, 255)), 1'b0, -1, -1);
                resync_next = 1'b0;
            end else if (sel < 86) begin
                queue_byte(cfg_sync1, lead_delta());
                queue_byte(cfg_sync2 ^ 8'($urandom_range(1, 255)), normal_delta());
                resync_next = 1'b0;
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    queue_byte(8'($urandom_range(0, 255)),
                               ($urandom_range(0, 3) == 0) ? $urandom() : normal_delta());
                end
                resync_next = 1'b1;
            end
        end
    endtask

    // APB write: setup then access, register taken once pready is seen
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= sfd_pkg::APB_ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            sfd_pkg::REG_FIRST_SYNC:  cfg_sync1 = value[7:0];
            sfd_pkg::REG_SECOND_SYNC: cfg_sync2 = value[7:0];
            sfd_pkg::REG_GAP_TIMEOUT: cfg_gap = value[15:0];
            default: ;
        endcase
    endtask

    // Upper data bits carry junk; the block keeps only the register width
    task automatic set_config(input logic [7:0] s1, input logic [7:0] s2, input logic [15:0] gap);
        apb_write(sfd_pkg::REG_FIRST_SYNC, {24'($urandom()), s1});
        apb_write(sfd_pkg::REG_SECOND_SYNC, {24'($urandom()), s2});
        apb_write(sfd_pkg::REG_GAP_TIMEOUT, {16'($urandom()), gap});
    endtask

    task automatic wait_drained();
        while (rx_queue.size() != 0 || in_ch.valid || expected_events.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTS) begin
            $display("[%0t] beat %0d: %s", $realtime, beats_checked, what);
        end
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
        end
    endtask

    // Byte driver: offers the head of rx_queue, predicts each accepted beat
    int src_gap = 0;
    int src_calm = 0;
    always @(posedge i_clk) begin
        t_deframe_beat want;
        t_rx_item      it;
        bit            took;
        int            roll;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            took = in_ch.valid && in_ch.ready;
            if (took) begin
                it = rx_queue.pop_front();
                deframe_byte(it.rx_byte, it.arrival_ms, want);
                expected_events.push_back(want);
                if (src_calm > 0) begin
                    src_calm--;
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 25) begin
                        src_gap = idle_len();
                    end else if (roll >= 97) begin
                        src_calm = $urandom_range(30, 120);
                    end
                end
            end
            if (!in_ch.valid || took) begin
                if (src_gap > 0) begin
                    src_gap--;
                    in_ch.valid <= 1'b0;
                end else if (rx_queue.size() != 0) begin
                    in_ch.valid      <= 1'b1;
                    in_ch.rx_byte    <= rx_queue[0].rx_byte;
                    in_ch.arrival_ms <= rx_queue[0].arrival_ms;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result sink: random stalls, quiet stretches, and long hold-offs on request
    int sink_stall = 0;
    int sink_calm = 0;
    always @(posedge i_clk) begin
        int roll;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_requests != holds_served) begin
            holds_served++;
            sink_stall = HOLD_CYCLES - 1;
            out_ch.ready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            out_ch.ready <= 1'b0;
        end else if (sink_calm > 0) begin
            sink_calm--;
            out_ch.ready <= 1'b1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                sink_calm = $urandom_range(30, 120);
                out_ch.ready <= 1'b1;
            end else if (roll < 15) begin
                sink_stall = idle_len() - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Result monitor: each beat against the oldest prediction
    always @(posedge i_clk) begin
        t_deframe_beat want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_events.size() == 0) begin
                report_mismatch("result beat with nothing predicted");
            end else begin
                want = expected_events.pop_front();
                check_field("event_res", 32'(out_ch.event_res), 32'(want.ev_code));
                check_field("payload_data", 32'(out_ch.payload_data), 32'(want.pay_data));
                check_field("payload_index", 32'(out_ch.payload_index), 32'(want.pay_index));
                check_field("pkt_cmd", 32'(out_ch.pkt_cmd), 32'(want.cmd));
                check_field("pkt_seq", 32'(out_ch.pkt_seq), 32'(want.seq));
                check_field("pkt_flags", 32'(out_ch.pkt_flags), 32'(want.flags));
                check_field("pkt_length", 32'(out_ch.pkt_length), 32'(want.pkt_len));
                check_field("ok_total", out_ch.ok_total, want.ok_cnt);
                check_field("crc_fail_total", out_ch.crc_fail_total, want.err_cnt);
            end
            beats_checked++;
        end
    end

    // Watchdog: too long without any beat or register access
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Sequence of phases
    initial begin
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_ch.valid      = 1'b0;
        in_ch.rx_byte    = '0;
        in_ch.arrival_ms = '0;
        out_ch.ready     = 1'b0;
        cfg_sync1        = sfd_pkg::FIRST_SYNC_RST;
        cfg_sync2        = sfd_pkg::SECOND_SYNC_RST;
        cfg_gap          = sfd_pkg::GAP_TIMEOUT_RST;
        restart_shadow();
        sh_cmd     = '0;
        sh_seq     = '0;
        sh_flags   = '0;
        sh_crc_lo  = '0;
        sh_last_ms = '0;
        sh_ok      = '0;
        sh_err     = '0;
        // start close to the wrap so the timestamp rolls over early
        ts_now = 32'hFFFF_FFF8;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset settings: zero length, payload with bad CRC, timeout,
        // bad second sync, oversize length
        queue_frame(16'd0, 8'hFF, 16'hFFFF, 8'h00, 1'b0, -1, -1);
        queue_frame(16'd1, 8'h00, 16'h0000, 8'hFF, 1'b1, -1, -1);
        queue_byte(cfg_sync1, normal_delta());
        queue_byte(cfg_sync1, timeout_delta());
        queue_byte(~cfg_sync2, normal_delta());
        queue_frame(16'(MAX_LEN + 1), 8'h5A, 16'h1234, 8'hA5, 1'b0, -1, -1);
        wait_drained();

        // Low extremes, no gap allowed; long sink hold-off while the queue is full
        set_config(8'h00, 8'hFF, 16'd0);
        queue_random_traffic(BYTES_PER_PHASE);
        hold_requests++;
        wait_drained();

        // High extremes
        set_config(8'hFF, 8'h00, 16'hFFFF);
        queue_random_traffic(BYTES_PER_PHASE);
        wait_drained();

        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   16'($urandom_range(1, 1000)));
        queue_random_traffic(BYTES_PER_PHASE);
        wait_drained();

        // Both sync bytes equal, tight gap
        set_config(8'h7E, 8'h7E, 16'd5);
        queue_random_traffic(BYTES_PER_PHASE);
        wait_drained();

        set_config(sfd_pkg::FIRST_SYNC_RST, sfd_pkg::SECOND_SYNC_RST, sfd_pkg::GAP_TIMEOUT_RST);
        queue_random_traffic(BYTES_PER_PHASE);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_events.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### filelist.f
sv/sfd_pkg.sv
sv/sfd_if.sv
sv/sfd_cfg_regs.sv
sv/sync_frame_deframer_crc16_unit.sv
test/sync_frame_deframer_crc16_unit_test.sv
